FILE: design/srs_pkg.sv
// Shared constants, register codes and controller/datapath structs of the resampler.
`default_nettype none

package srs_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned MAX_OUT_FRAMES_DEF  = 4096;
  localparam int unsigned SAMPLE_BITS_DEF     = 24;
  localparam int unsigned MAX_OUTS_PER_IN_DEF = 16;

  // Phase accumulator format: Q5.20 unsigned.
  localparam int unsigned PH_FRAC_BITS = 20;
  localparam int unsigned PH_W         = 25;
  localparam int unsigned STEP_W       = 24;
  localparam logic [PH_W-1:0] PH_ONE = PH_W'(1) << PH_FRAC_BITS;
  localparam logic [PH_W-1:0] PH_TWO = PH_W'(2) << PH_FRAC_BITS;

  // Smallest usable phase step (1/16) and the step after reset (1.0).
  localparam logic [STEP_W-1:0] PH_MIN     = STEP_W'(1) << (PH_FRAC_BITS - 4);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << PH_FRAC_BITS;

  // Output sample width; full scale is 2^(OUT_W-1)-1.
  localparam int unsigned OUT_W = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 2'd0,
    REG_PHASE_STEP  = 2'd1,
    REG_MONO_SOURCE = 2'd2
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the accepted source frame
    logic fresh;   // block start: restart phase, frame becomes previous
    logic iter;    // one phase position: issue candidate, advance phase
    logic hold;    // iteration belongs to the trailing hold of a block
    logic wrap;    // end of interpolation: phase minus one, shift frames
    logic finish;  // end of block: clear phase, frame and output count
  } srs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic have_prev;
    logic last;
    logic phase_lt_one;
    logic adv;
  } srs_status_t;

endpackage

`default_nettype wire

FILE: design/srs_if.sv
// Request channel interfaces of the resampler: source frames, result frames, configuration.
`default_nettype none

interface srs_in_if #(
  parameter int unsigned SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          block_last;

  modport source (output valid, left_in, right_in, block_last, input ready);
  modport sink   (input valid, left_in, right_in, block_last, output ready);
endinterface

interface srs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [srs_pkg::OUT_W-1:0]  left_out;
  logic signed [srs_pkg::OUT_W-1:0]  right_out;
  logic                              run_last;
  logic                              block_end;

  modport source (output valid, left_out, right_out, run_last, block_end, input ready);
  modport sink   (input valid, left_out, right_out, run_last, block_end, output ready);
endinterface

interface srs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [srs_pkg::CFG_IDX_W-1:0]    index;
  logic [srs_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/stereo_linear_resampler_s16.sv
// Top level of the stereo linear-interpolation resampler with its configuration registers.
//
// Channel    Dir  Payload                                   Accepted when
// samples_i  in   left_in, right_in, block_last             valid & ready
// frames_o   out  left_out, right_out, run_last, block_end  valid & ready
// cfg_i      in   index, data                               valid & ready (always ready)
//
// A source frame is accepted, then each phase position of the interpolation run is
// stepped and the run is closed; on the last frame of a block, each trailing hold
// position follows and the block is closed.
// The phase accumulator steps one phase position per cycle while the output pipe is not
// stalled; results leave through the product stage and the output register.
// Reset clears the phase, the frame history and the block count; no clearing pass.
// A stalled result freezes the whole output pipe and the phase stepping with it.
`default_nettype none

module stereo_linear_resampler_s16 #(
  parameter int unsigned MAX_OUT_FRAMES  = srs_pkg::MAX_OUT_FRAMES_DEF,
  parameter int unsigned SAMPLE_BITS     = srs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_OUTS_PER_IN = srs_pkg::MAX_OUTS_PER_IN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  srs_in_if.sink     samples_i,
  srs_out_if.source  frames_o,
  srs_cfg_if.sink    cfg_i
);

  logic                          enable_q;
  logic [srs_pkg::STEP_W-1:0]    phase_step_q;
  logic                          mono_source_q;

  srs_pkg::srs_cmd_t    cmd;
  srs_pkg::srs_status_t status;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      phase_step_q  <= srs_pkg::STEP_RESET;
      mono_source_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        srs_pkg::REG_ENABLE:      enable_q      <= cfg_i.data[0];
        srs_pkg::REG_PHASE_STEP:  phase_step_q  <= cfg_i.data[srs_pkg::STEP_W-1:0];
        srs_pkg::REG_MONO_SOURCE: mono_source_q <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  srs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enable_i   (enable_q),
    .in_valid_i (samples_i.valid),
    .in_last_i  (samples_i.block_last),
    .status_i   (status),
    .in_ready_o (samples_i.ready),
    .cmd_o      (cmd)
  );

  // Datapath.
  srs_dp #(
    .MAX_OUT_FRAMES  (MAX_OUT_FRAMES),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .MAX_OUTS_PER_IN (MAX_OUTS_PER_IN)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .phase_step_i (phase_step_q),
    .mono_i       (mono_source_q),
    .in_left_i    (samples_i.left_in),
    .in_right_i   (samples_i.right_in),
    .in_last_i    (samples_i.block_last),
    .out_ready_i  (frames_o.ready),
    .status_o     (status),
    .out_valid_o  (frames_o.valid),
    .left_o       (frames_o.left_out),
    .right_o      (frames_o.right_out),
    .run_last_o   (frames_o.run_last),
    .block_end_o  (frames_o.block_end)
  );

  // Results never reach the most negative code of the 16-bit range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_o.valid |-> (frames_o.left_out >= -16'sd32767) &&
                       (frames_o.right_out >= -16'sd32767))
    else $error("result sample below negative full scale");

  // A block end is always the last result of its source frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_o.valid && frames_o.block_end |-> frames_o.run_last)
    else $error("block end without run end");

  // Closing a block drops the frame history.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> !status.have_prev)
    else $error("frame history kept past block end");

  // A frame that continues a block starts an interpolation run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    samples_i.valid && samples_i.ready && enable_q && status.have_prev
    |=> !samples_i.ready)
    else $error("continuing frame did not start an interpolation run");

endmodule

`default_nettype wire

FILE: design/srs_ctrl.sv
// Sequencing state machine of the resampler: interpolation run, trailing hold, block end.
`default_nettype none

module srs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 enable_i,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  input  srs_pkg::srs_status_t status_i,
  output logic                 in_ready_o,
  output srs_pkg::srs_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_INTERP = 2'd1;
  localparam logic [1:0] ST_HOLD  = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && enable_i) begin
          cmd_o.load = 1'b1;
          if (status_i.have_prev) begin
            state_d = ST_INTERP;
          end else begin
            cmd_o.fresh = 1'b1;
            state_d     = in_last_i ? ST_HOLD : ST_IDLE;
          end
        end
      end
      ST_INTERP: begin
        if (!status_i.phase_lt_one) begin
          cmd_o.wrap = 1'b1;
          state_d    = status_i.last ? ST_HOLD : ST_IDLE;
        end else if (status_i.adv) begin
          cmd_o.iter = 1'b1;
        end
      end
      ST_HOLD: begin
        if (!status_i.phase_lt_one) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else if (status_i.adv) begin
          cmd_o.iter = 1'b1;
          cmd_o.hold = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/srs_dp.sv
// Datapath of the resampler: frame and phase registers, interpolation multiplier, output stage.
`default_nettype none

module srs_dp #(
  parameter int unsigned MAX_OUT_FRAMES  = srs_pkg::MAX_OUT_FRAMES_DEF,
  parameter int unsigned SAMPLE_BITS     = srs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_OUTS_PER_IN = srs_pkg::MAX_OUTS_PER_IN_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  srs_pkg::srs_cmd_t                  cmd_i,
  input  logic [srs_pkg::STEP_W-1:0]         phase_step_i,
  input  logic                               mono_i,
  input  logic signed [SAMPLE_BITS-1:0]      in_left_i,
  input  logic signed [SAMPLE_BITS-1:0]      in_right_i,
  input  logic                               in_last_i,
  input  logic                               out_ready_i,
  output srs_pkg::srs_status_t               status_o,
  output logic                               out_valid_o,
  output logic signed [srs_pkg::OUT_W-1:0]   left_o,
  output logic signed [srs_pkg::OUT_W-1:0]   right_o,
  output logic                               run_last_o,
  output logic                               block_end_o
);

  localparam int unsigned PH_W    = srs_pkg::PH_W;
  localparam int unsigned FRAC_W  = srs_pkg::PH_FRAC_BITS;
  localparam int unsigned OUT_W   = srs_pkg::OUT_W;
  localparam int unsigned DIFF_W  = SAMPLE_BITS + 1;
  localparam int unsigned PROD_W  = DIFF_W + FRAC_W + 1;
  localparam int unsigned SUM_W   = SAMPLE_BITS + 2;
  localparam int unsigned CLP_W   = SAMPLE_BITS - 1;
  localparam int unsigned SCL_W   = CLP_W + OUT_W - 1;
  localparam int unsigned ONE_SH  = SAMPLE_BITS - 3;
  localparam int unsigned NCNT_W  = $clog2(MAX_OUTS_PER_IN + 1);
  localparam int unsigned CNT_W   = $clog2(MAX_OUT_FRAMES + 1);

  localparam logic signed [SUM_W-1:0] POS_ONE = SUM_W'(64'sd1 <<< ONE_SH);
  localparam logic signed [SUM_W-1:0] NEG_ONE = -POS_ONE;
  localparam logic signed [SCL_W-1:0] TRUNC_BIAS = SCL_W'((64'sd1 <<< ONE_SH) - 64'sd1);

  // Adds the interpolation term, clamps to +-1.0 and scales to full scale,
  // truncating toward zero.
  function automatic logic signed [OUT_W-1:0] to_s16(
    input logic signed [SAMPLE_BITS-1:0] base,
    input logic signed [PROD_W-1:0]      prod
  );
    logic signed [PROD_W-1:0] quot;
    logic signed [SUM_W-1:0]  sum;
    logic signed [CLP_W-1:0]  v;
    logic signed [SCL_W-1:0]  w;
    logic signed [SCL_W-1:0]  res;
    quot = prod >>> FRAC_W;
    sum  = SUM_W'(base) + SUM_W'(quot);
    if (sum > POS_ONE) begin
      v = CLP_W'(POS_ONE);
    end else if (sum < NEG_ONE) begin
      v = CLP_W'(NEG_ONE);
    end else begin
      v = CLP_W'(sum);
    end
    w   = (SCL_W'(v) <<< (OUT_W - 1)) - SCL_W'(v);
    res = (w + (w[SCL_W-1] ? TRUNC_BIAS : SCL_W'(0))) >>> ONE_SH;
    return OUT_W'(res);
  endfunction

  // Control registers.
  logic                 have_prev_q;
  logic                 last_q;
  logic [PH_W-1:0]      phase_q;
  logic [NCNT_W-1:0]    n_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 s1_valid_q;
  logic                 out_valid_q;

  // Payload registers.
  logic signed [SAMPLE_BITS-1:0] cur_l_q, cur_r_q, prev_l_q, prev_r_q;
  logic signed [SAMPLE_BITS-1:0] s1_base_l_q, s1_base_r_q;
  logic signed [PROD_W-1:0]      s1_prod_l_q, s1_prod_r_q;
  logic                          s1_run_last_q, s1_block_end_q;
  logic signed [OUT_W-1:0]       left_q, right_q;
  logic                          run_last_q, block_end_q;

  logic signed [SAMPLE_BITS-1:0] in_r_sel;
  logic [srs_pkg::STEP_W-1:0]    step_eff;
  logic [PH_W-1:0]               phase_sum;
  logic                          adv;
  logic                          emit_ok;
  logic                          next_exists;
  logic                          more_emit;
  logic                          cand_run_last;
  logic signed [DIFF_W-1:0]      diff_l, diff_r;
  logic signed [FRAC_W:0]        frac_s;
  logic signed [PROD_W-1:0]      prod_l, prod_r;

  // Mono source select, phase step floor, phase advance and the stall signal of the output pipe.
  assign in_r_sel  = mono_i ? in_left_i : in_right_i;
  assign step_eff  = (phase_step_i < srs_pkg::PH_MIN) ? srs_pkg::PH_MIN : phase_step_i;
  assign phase_sum = phase_q + PH_W'(step_eff);
  assign adv       = !out_valid_q || out_ready_i;

  // An output is kept while both the per-frame and the per-block budgets last.
  assign emit_ok = (n_q < NCNT_W'(MAX_OUTS_PER_IN)) && (cnt_q < CNT_W'(MAX_OUT_FRAMES));

  // Look ahead one phase position to know whether this output ends the run.
  always_comb begin
    if (cmd_i.hold) begin
      next_exists = phase_sum < srs_pkg::PH_ONE;
    end else begin
      next_exists = (phase_sum < srs_pkg::PH_ONE) ||
                    (last_q && (phase_sum < srs_pkg::PH_TWO));
    end
  end
  assign more_emit = next_exists && (n_q < NCNT_W'(MAX_OUTS_PER_IN - 1)) &&
                     (cnt_q < CNT_W'(MAX_OUT_FRAMES - 1));
  assign cand_run_last = !more_emit;

  // Interpolation product; in the trailing hold both frames are equal, so
  // the product is zero there.
  assign diff_l = DIFF_W'(cur_l_q) - DIFF_W'(prev_l_q);
  assign diff_r = DIFF_W'(cur_r_q) - DIFF_W'(prev_r_q);
  assign frac_s = $signed({1'b0, phase_q[FRAC_W-1:0]});
  assign prod_l = diff_l * frac_s;
  assign prod_r = diff_r * frac_s;

  // Phase, frame bookkeeping and pipe valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      last_q      <= 1'b0;
      phase_q     <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        last_q <= in_last_i;
        n_q    <= '0;
      end
      if (cmd_i.fresh) begin
        phase_q     <= '0;
        have_prev_q <= 1'b1;
      end
      if (cmd_i.iter) begin
        phase_q <= phase_sum;
        if (emit_ok) begin
          n_q   <= NCNT_W'(n_q + 1'b1);
          cnt_q <= CNT_W'(cnt_q + 1'b1);
        end
      end
      if (cmd_i.wrap) begin
        phase_q     <= phase_q - srs_pkg::PH_ONE;
        have_prev_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        phase_q     <= '0;
        have_prev_q <= 1'b0;
        cnt_q       <= '0;
      end
      if (adv) begin
        s1_valid_q  <= cmd_i.iter && emit_ok;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Source frames.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_l_q <= in_left_i;
      cur_r_q <= in_r_sel;
    end
    if (cmd_i.fresh) begin
      prev_l_q <= in_left_i;
      prev_r_q <= in_r_sel;
    end else if (cmd_i.wrap) begin
      prev_l_q <= cur_l_q;
      prev_r_q <= cur_r_q;
    end
  end

  // Product stage and output register, moving together when the pipe advances.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_base_l_q    <= prev_l_q;
      s1_base_r_q    <= prev_r_q;
      s1_prod_l_q    <= prod_l;
      s1_prod_r_q    <= prod_r;
      s1_run_last_q  <= cand_run_last;
      s1_block_end_q <= cand_run_last && last_q;
      left_q         <= to_s16(s1_base_l_q, s1_prod_l_q);
      right_q        <= to_s16(s1_base_r_q, s1_prod_r_q);
      run_last_q     <= s1_run_last_q;
      block_end_q    <= s1_block_end_q;
    end
  end

  assign status_o.have_prev    = have_prev_q;
  assign status_o.last         = last_q;
  assign status_o.phase_lt_one = phase_q < srs_pkg::PH_ONE;
  assign status_o.adv          = adv;

  assign out_valid_o = out_valid_q;
  assign left_o      = left_q;
  assign right_o     = right_q;
  assign run_last_o  = run_last_q;
  assign block_end_o = block_end_q;

endmodule

`default_nettype wire
